// ----- rtl/core/wre_pkg.sv -----
// Shared types, constants and calendar helpers for the weekly recurrence expander.
package wre_pkg;

  localparam int MaxOccDefault = 64;
  localparam logic [5:0] WeekDays = 6'd7;
  localparam logic [3:0] MonthDec = 4'd12;
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [10:0] Recip25 = 11'd1311;
  localparam int Recip25Shift = 15;
  localparam logic [7:0] Twenty5 = 8'd25;

  typedef struct packed {
    logic [11:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [16:0] start_secs;
    logic [11:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [16:0] end_secs;
    logic [11:0] until_year;
    logic [3:0]  until_month;
    logic [4:0]  until_day;
    logic [16:0] until_secs;
  } evt_t;

  typedef struct packed {
    logic [11:0] occ_start_year;
    logic [3:0]  occ_start_month;
    logic [4:0]  occ_start_day;
    logic [16:0] occ_start_secs;
    logic [11:0] occ_end_year;
    logic [3:0]  occ_end_month;
    logic [4:0]  occ_end_day;
    logic [16:0] occ_end_secs;
    logic        last_of_run;
    logic        truncated;
  } occ_t;

  typedef struct packed {
    logic load;
    logic advance;
  } wre_cmd_t;

  typedef struct packed {
    logic last;
    logic trunc;
  } wre_status_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    if (m == 4'd0) begin
      return MonthJan;
    end else if (m > MonthDec) begin
      return MonthDec;
    end
    return m;
  endfunction

  function automatic logic [4:0] fix_day(input logic [4:0] d);
    return (d == 5'd0) ? 5'd1 : d;
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    logic [22:0] prod;
    logic [7:0]  q;
    logic [11:0] back;
    logic        div25;
    prod  = 23'(y) * 23'(Recip25);
    q     = prod[Recip25Shift +: 8];
    back  = 12'(q) * 12'(Twenty5);
    div25 = (back == y);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      MonthFeb:                n = is_leap(y) ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic date_t add_week(input date_t a);
    date_t      r;
    logic [5:0] day;
    logic [4:0] len;
    r   = a;
    day = 6'(a.day) + WeekDays;
    len = days_in(a.year, a.month);
    if (day > 6'(len)) begin
      day = day - 6'(len);
      if (a.month == MonthDec) begin
        r.month = MonthJan;
        r.year  = a.year + 12'd1;
      end else begin
        r.month = a.month + 4'd1;
      end
    end
    r.day = day[4:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/wre_datapath.sv -----
// Occurrence registers, weekly date stepping, until compare and run counter.
module wre_datapath import wre_pkg::*; #(
  parameter int MAX_OCCURRENCES = MaxOccDefault
) (
  input  logic        clk,
  input  evt_t        evt,
  input  wre_cmd_t    cmd,
  output wre_status_t status,
  output occ_t        occ
);

  localparam int CntW = (MAX_OCCURRENCES > 1) ? $clog2(MAX_OCCURRENCES) : 1;

  date_t       sdate;
  date_t       edate;
  logic [16:0] ssecs;
  logic [16:0] esecs;
  logic [37:0] until_key;
  logic        rule;
  logic [CntW-1:0] count;

  date_t sdate_next;
  date_t edate_next;
  logic  more;
  logic  at_cap;

  assign sdate_next = add_week(sdate);
  assign edate_next = add_week(edate);
  assign more   = rule && ({sdate_next.year, sdate_next.month, sdate_next.day, ssecs} < until_key);
  assign at_cap = (count == CntW'(MAX_OCCURRENCES - 1));

  assign status.last  = !more || at_cap;
  assign status.trunc = more && at_cap;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sdate     <= '{year: evt.start_year, month: clamp_month(evt.start_month),
                     day: fix_day(evt.start_day)};
      edate     <= '{year: evt.end_year, month: clamp_month(evt.end_month),
                     day: fix_day(evt.end_day)};
      ssecs     <= evt.start_secs;
      esecs     <= evt.end_secs;
      until_key <= {evt.until_year, evt.until_month, evt.until_day, evt.until_secs};
      rule      <= (evt.until_year != 12'd0);
      count     <= '0;
    end else if (cmd.advance) begin
      sdate <= sdate_next;
      edate <= edate_next;
      count <= count + CntW'(1);
    end
  end

  always_comb begin
    occ.occ_start_year  = sdate.year;
    occ.occ_start_month = sdate.month;
    occ.occ_start_day   = sdate.day;
    occ.occ_start_secs  = ssecs;
    occ.occ_end_year    = edate.year;
    occ.occ_end_month   = edate.month;
    occ.occ_end_day     = edate.day;
    occ.occ_end_secs    = esecs;
    occ.last_of_run     = status.last;
    occ.truncated       = status.trunc;
  end

endmodule

// ----- rtl/core/wre_ctrl.sv -----
// Run controller: takes an item, then emits one occurrence per cycle until the last.
module wre_ctrl import wre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  wre_status_t status,
  output wre_cmd_t    cmd,
  output logic        busy,
  output logic        strobe
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = EMIT;
        end
      end
      EMIT: begin
        cmd.advance = 1'b1;
        if (status.last) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  assign busy   = (state != IDLE);
  assign strobe = (state == EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_emits: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> strobe) else $error("accepted item gave no occurrence");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && status.last |=> !strobe) else $error("run continued past last");
  a_more_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !status.last |=> strobe) else $error("run stopped early");
  a_trunc_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status.trunc |-> status.last) else $error("truncated without last");

endmodule

// ----- rtl/core/weekly_recurrence_expander.sv -----
// Top level of the weekly recurrence expander: controller plus datapath.
//
//   port     dir  width  role
//   start    in   1      item request, taken when busy is low
//   busy     out  1      high while a run is in progress
//   evt      in   evt_t  event item: start, end and until date-times
//   strobe   out  1      one occurrence on occ this cycle
//   occ      out  occ_t  occurrence item with last_of_run and truncated
//
// An item is taken while busy is low, then N occurrences follow, one per cycle.
// N runs from 1 to MAX_OCCURRENCES, and no new item is taken until the last has gone;
// each date step is combinational and lands in the occurrence registers on advance.
// Synchronous reset returns the controller to idle; no run is in flight.
// The receiver cannot stall: each occurrence is valid for one cycle only.
module weekly_recurrence_expander import wre_pkg::*; #(
  parameter int MAX_OCCURRENCES = MaxOccDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  evt_t evt,
  output logic strobe,
  output occ_t occ
);

  wre_cmd_t    cmd;
  wre_status_t status;

  wre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  wre_datapath #(
    .MAX_OCCURRENCES (MAX_OCCURRENCES)
  ) u_datapath (
    .clk    (clk),
    .evt    (evt),
    .cmd    (cmd),
    .status (status),
    .occ    (occ)
  );

endmodule

// ----- bench/occ_check_pkg.sv -----
// Calendar stepping, occurrence expansion and the occurrence scoreboard for the bench.
package occ_check_pkg;
  import wre_pkg::*;

  localparam int MaxOcc = MaxOccDefault;
  localparam int DaysPerWeek = 7;

  function automatic bit leap_year(logic [11:0] y);
    int yi;
    yi = y;
    return (yi % 4 == 0) && ((yi % 100 != 0) || (yi % 400 == 0));
  endfunction

  function automatic logic [4:0] month_days(logic [11:0] y, logic [3:0] m);
    case (m)
      MonthFeb: return leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [3:0] norm_month(logic [3:0] m);
    if (m == 4'd0) return MonthJan;
    if (m > MonthDec) return MonthDec;
    return m;
  endfunction

  function automatic date_t next_week(date_t a);
    date_t r;
    logic [5:0] d;
    logic [5:0] len;
    r = a;
    len = 6'(month_days(a.year, a.month));
    d = 6'(a.day) + 6'(DaysPerWeek);
    if (d > len) begin
      d = d - len;
      if (a.month == MonthDec) begin
        r.month = MonthJan;
        r.year = a.year + 12'd1;
      end else begin
        r.month = a.month + 4'd1;
      end
    end
    r.day = d[4:0];
    return r;
  endfunction

  function automatic date_t weeks_after(date_t a, int k);
    date_t r;
    r = a;
    for (int i = 0; i < k; i++) r = next_week(r);
    return r;
  endfunction

  class occ_scoreboard;
    occ_t expected_occ[$];
    int errors;
    int n_events;
    int n_checked;
    int n_capped;
    int n_single;

    function new();
      errors = 0;
      n_events = 0;
      n_checked = 0;
      n_capped = 0;
      n_single = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void expand_event(evt_t e);
      date_t s, f, ns, nf;
      logic [16:0] ss, fs;
      logic [37:0] until_key;
      bit rule, more;
      occ_t o;
      int n;
      s = {e.start_year, norm_month(e.start_month),
           (e.start_day == 5'd0) ? 5'd1 : e.start_day};
      f = {e.end_year, norm_month(e.end_month), (e.end_day == 5'd0) ? 5'd1 : e.end_day};
      ss = e.start_secs;
      fs = e.end_secs;
      until_key = {e.until_year, e.until_month, e.until_day, e.until_secs};
      rule = (e.until_year != 12'd0);
      n = 0;
      n_events++;
      forever begin
        o = '0;
        {o.occ_start_year, o.occ_start_month, o.occ_start_day} = s;
        o.occ_start_secs = ss;
        {o.occ_end_year, o.occ_end_month, o.occ_end_day} = f;
        o.occ_end_secs = fs;
        n++;
        ns = next_week(s);
        nf = next_week(f);
        more = rule && ({ns, ss} < until_key);
        if (!more || n >= MaxOcc) begin
          o.last_of_run = 1'b1;
          o.truncated = more;
          expected_occ.push_back(o);
          if (more) n_capped++;
          if (n == 1) n_single++;
          break;
        end
        expected_occ.push_back(o);
        s = ns;
        f = nf;
      end
    endfunction

    task cmp_field(string name, logic [16:0] got, logic [16:0] want);
      if (got !== want)
        report($sformatf("occurrence %0d %s: got %0d, expected %0d",
                         n_checked, name, got, want));
    endtask

    task check_occ(occ_t got);
      occ_t want;
      if (expected_occ.size() == 0) begin
        report($sformatf("unexpected occurrence %p", got));
        return;
      end
      want = expected_occ.pop_front();
      n_checked++;
      cmp_field("occ_start_year", 17'(got.occ_start_year), 17'(want.occ_start_year));
      cmp_field("occ_start_month", 17'(got.occ_start_month), 17'(want.occ_start_month));
      cmp_field("occ_start_day", 17'(got.occ_start_day), 17'(want.occ_start_day));
      cmp_field("occ_start_secs", got.occ_start_secs, want.occ_start_secs);
      cmp_field("occ_end_year", 17'(got.occ_end_year), 17'(want.occ_end_year));
      cmp_field("occ_end_month", 17'(got.occ_end_month), 17'(want.occ_end_month));
      cmp_field("occ_end_day", 17'(got.occ_end_day), 17'(want.occ_end_day));
      cmp_field("occ_end_secs", got.occ_end_secs, want.occ_end_secs);
      cmp_field("last_of_run", 17'(got.last_of_run), 17'(want.last_of_run));
      cmp_field("truncated", 17'(got.truncated), 17'(want.truncated));
    endtask
  endclass

endpackage

// ----- bench/tb.sv -----
// Testbench top for the weekly recurrence expander: stimulus, monitor and watchdog.
module tb;
  import wre_pkg::*;
  import occ_check_pkg::*;

  localparam int StallLimit = 1000;
  localparam int RandomEvents = 360;
  localparam int RunCycles = MaxOcc + 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  evt_t evt = '0;
  logic busy;
  logic strobe;
  occ_t occ;

  occ_scoreboard sb;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  weekly_recurrence_expander #(.MAX_OCCURRENCES(MaxOcc)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .evt(evt),
    .strobe(strobe),
    .occ(occ)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_occ(occ);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (strobe && sb.expected_occ.size() != 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic date_t dt(int y, int m, int d);
    return {12'(y), 4'(m), 5'(d)};
  endfunction

  function automatic evt_t mk(date_t s, logic [16:0] ss, date_t f, logic [16:0] fs,
                              date_t u, logic [16:0] us);
    return {s, ss, f, fs, u, us};
  endfunction

  function automatic date_t legal_date();
    logic [11:0] y;
    logic [3:0] m;
    logic [4:0] d;
    case ($urandom_range(0, 11))
      0: y = 12'd1900;
      1: y = 12'd2000;
      2: y = 12'd4095;
      3: y = 12'd2099;
      default: y = 12'($urandom_range(1900, 2099));
    endcase
    m = 4'($urandom_range(1, 12));
    if ($urandom_range(0, 9) == 0) d = 5'($urandom_range(1, 31));
    else d = 5'($urandom_range(1, month_days(y, m)));
    return {y, m, d};
  endfunction

  function automatic evt_t rand_event();
    evt_t e;
    date_t s, f, u;
    logic [16:0] ss, us;
    logic [159:0] raw;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind >= 72) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return raw[$bits(evt_t)-1:0];
    end
    s = legal_date();
    f = $urandom_range(0, 1) ? s : legal_date();
    ss = 17'($urandom_range(0, 86399));
    u = weeks_after(s, $urandom_range(0, 66));
    case ($urandom_range(0, 3))
      0: us = ss;
      1: us = ss + 17'd1;
      2: us = ss - 17'd1;
      default: us = 17'($urandom_range(0, 86399));
    endcase
    e = {s, ss, f, 17'($urandom_range(0, 86399)), u, us};
    if (kind < 12) e.until_year = '0;
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task send_event(evt_t e);
    @(negedge clk);
    start <= 1'b1;
    evt <= e;
    do @(posedge clk); while (busy !== 1'b0);
    sb.expand_event(e);
  endtask

  task idle_for(int n);
    logic [159:0] raw;
    if (n > 0) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      @(negedge clk);
      start <= 1'b0;
      evt <= raw[$bits(evt_t)-1:0];
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task wait_drained();
    idle_for(1);
    while (sb.expected_occ.size() != 0) @(posedge clk);
  endtask

  initial begin
    evt_t directed[$];
    date_t s64;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    s64 = dt(2021, 1, 4);
    directed.push_back(mk(dt(2024, 3, 15), 17'd36000, dt(2024, 3, 15), 17'd39600,
                          dt(0, 1, 1), 17'd0));
    directed.push_back('0);
    directed.push_back('1);
    directed.push_back(mk(dt(2050, 6, 10), 17'd0, dt(2050, 6, 10), 17'd100,
                          dt(2050, 6, 9), 17'd86399));
    directed.push_back(mk(dt(2023, 5, 1), 17'd3600, dt(2023, 5, 1), 17'd7200,
                          dt(2023, 5, 8), 17'd3600));
    directed.push_back(mk(dt(2023, 5, 1), 17'd3600, dt(2023, 5, 1), 17'd7200,
                          dt(2023, 5, 8), 17'd3601));
    directed.push_back(mk(dt(2023, 2, 31), 17'd0, dt(2023, 2, 31), 17'd0,
                          dt(2023, 4, 30), 17'd86399));
    directed.push_back(mk(dt(2000, 2, 25), 17'd43200, dt(2000, 2, 26), 17'd0,
                          dt(2000, 4, 1), 17'd0));
    directed.push_back(mk(dt(1900, 2, 25), 17'd43200, dt(1900, 2, 26), 17'd0,
                          dt(1900, 4, 1), 17'd0));
    directed.push_back(mk(dt(2024, 2, 27), 17'd600, dt(2024, 2, 28), 17'd600,
                          dt(2024, 4, 1), 17'd0));
    directed.push_back(mk(dt(0, 2, 25), 17'd0, dt(0, 2, 25), 17'd0, dt(1, 1, 1), 17'd0));
    directed.push_back(mk(dt(2099, 12, 28), 17'd0, dt(2100, 1, 2), 17'd0,
                          dt(2100, 2, 1), 17'd0));
    directed.push_back(mk(s64, 17'd500, s64, 17'd600, weeks_after(s64, 63), 17'd500));
    directed.push_back(mk(s64, 17'd500, s64, 17'd600, weeks_after(s64, 64), 17'd500));
    directed.push_back(mk(s64, 17'd500, s64, 17'd600, weeks_after(s64, 64), 17'd501));
    directed.push_back(mk(dt(2030, 1, 1), 17'd0, dt(2030, 1, 1), 17'd60,
                          dt(2030, 0, 5), 17'd0));
    directed.push_back(mk(dt(2030, 1, 1), 17'd0, dt(2030, 1, 1), 17'd60,
                          dt(2030, 15, 0), 17'd0));
    directed.push_back(mk(dt(2030, 7, 1), 17'd100000, dt(2030, 7, 1), 17'd131071,
                          dt(2030, 7, 8), 17'd100001));
    directed.push_back(mk(dt(2022, 13, 0), 17'd80000, dt(2022, 0, 30), 17'd86399,
                          dt(2023, 3, 1), 17'd0));
    directed.push_back(mk(dt(2022, 1, 30), 17'd82800, dt(2022, 2, 2), 17'd3600,
                          dt(2022, 6, 1), 17'd0));
    foreach (directed[i]) send_event(directed[i]);
    wait_drained();

    for (int i = 0; i < RandomEvents; i++) begin
      if (i == RandomEvents / 2) wait_drained();
      if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
      send_event(rand_event());
      idle_for(pick_gap());
    end
    wait_drained();
    repeat (RunCycles) @(posedge clk);

    if (sb.expected_occ.size() != 0)
      sb.report($sformatf("%0d occurrences never arrived", sb.expected_occ.size()));
    $display("Ran %0d events (%0d directed) and checked %0d occurrences.",
             sb.n_events, directed.size(), sb.n_checked);
    $display("Runs stopped at the cap: %0d; single-occurrence events: %0d; mismatches: %0d.",
             sb.n_capped, sb.n_single, sb.errors);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- weekly_recurrence_expander.f -----
rtl/core/wre_pkg.sv
rtl/core/wre_datapath.sv
rtl/core/wre_ctrl.sv
rtl/core/weekly_recurrence_expander.sv
bench/occ_check_pkg.sv
bench/tb.sv
